FILE: design/psd_gated_charge_integrator_defines.svh
`ifndef PSD_GATED_CHARGE_INTEGRATOR_DEFINES_SVH
`define PSD_GATED_CHARGE_INTEGRATOR_DEFINES_SVH

// same-cycle implication
`define PSD_GCI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSD_GCI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/psd_gci_pkg.sv
package psd_gci_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 14;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int LEN_W      = 12;
    localparam int SPE_W      = 13;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_ADDR_W-1:0] CFG_PRETRIGGER_LEN    = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_PREGATE_LEN       = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_GATE_LEN    = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_GATE_LEN     = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLES_PER_EVENT = CFG_ADDR_W'(4);

    localparam logic [LEN_W-1:0] PRETRIGGER_LEN_RST    = LEN_W'(64);
    localparam logic [LEN_W-1:0] PREGATE_LEN_RST       = LEN_W'(16);
    localparam logic [LEN_W-1:0] SHORT_GATE_LEN_RST    = LEN_W'(24);
    localparam logic [LEN_W-1:0] LONG_GATE_LEN_RST     = LEN_W'(100);
    localparam logic [SPE_W-1:0] SAMPLES_PER_EVENT_RST = SPE_W'(256);

    typedef struct packed {
        logic [LEN_W-1:0] pretrigger_len;
        logic [LEN_W-1:0] pregate_len;
        logic [LEN_W-1:0] short_gate_len;
        logic [LEN_W-1:0] long_gate_len;
        logic [SPE_W-1:0] samples_per_event;
    } psd_gci_cfg_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic mul_en;
        logic out_load;
    } psd_gci_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } psd_gci_sts_t;

    typedef enum logic [1:0] {
        S_ACCUM,
        S_DIV,
        S_MUL,
        S_LOAD
    } psd_gci_state_t;

endpackage

FILE: design/psd_gci_ctrl.sv
module psd_gci_ctrl #(
    parameter int DIV_STEPS = 34
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  psd_gci_pkg::psd_gci_sts_t sts,
    output psd_gci_pkg::psd_gci_cmd_t cmd
);

    localparam int CW = $clog2(DIV_STEPS);

    psd_gci_pkg::psd_gci_state_t state_reg, state_next;
    logic [CW-1:0] div_cnt_reg, div_cnt_next;
    logic          div_done;

    assign div_done = (div_cnt_reg == CW'(DIV_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= psd_gci_pkg::S_ACCUM;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            psd_gci_pkg::S_ACCUM: begin
                if (s_tvalid && sts.last) state_next = psd_gci_pkg::S_DIV;
            end
            psd_gci_pkg::S_DIV: begin
                if (div_done) state_next = psd_gci_pkg::S_MUL;
            end
            psd_gci_pkg::S_MUL: begin
                state_next = psd_gci_pkg::S_LOAD;
            end
            psd_gci_pkg::S_LOAD: begin
                if (sts.out_free) state_next = psd_gci_pkg::S_ACCUM;
            end
            default: state_next = psd_gci_pkg::S_ACCUM;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        div_cnt_next = '0;
        case (state_reg)
            psd_gci_pkg::S_ACCUM: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            psd_gci_pkg::S_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + CW'(1);
            end
            psd_gci_pkg::S_MUL: begin
                cmd.mul_en = 1'b1;
            end
            psd_gci_pkg::S_LOAD: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: design/psd_gci_datapath.sv
module psd_gci_datapath #(
    parameter int MAX_SAMPLES = psd_gci_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = psd_gci_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = psd_gci_pkg::FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  psd_gci_pkg::psd_gci_cfg_t cfg,
    input  logic [SAMPLE_BITS-1:0]    sample,
    input  logic                      event_start,
    input  psd_gci_pkg::psd_gci_cmd_t cmd,
    output psd_gci_pkg::psd_gci_sts_t sts,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [SAMPLE_BITS+FRAC_BITS-1:0] baseline_avg,
    output logic [$clog2(MAX_SAMPLES+1)+SAMPLE_BITS+FRAC_BITS-1:0] charge_short,
    output logic [$clog2(MAX_SAMPLES+1)+SAMPLE_BITS+FRAC_BITS-1:0] charge_long,
    output logic                      window_error
);

    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W    = SAMPLE_BITS + $clog2(MAX_SAMPLES);
    localparam int BASE_W   = SAMPLE_BITS + FRAC_BITS;
    localparam int CHARGE_W = CNT_W + BASE_W;
    localparam int DIVD_W   = SUM_W + FRAC_BITS;
    localparam int XW       = ((CNT_W > psd_gci_pkg::SPE_W) ? CNT_W : psd_gci_pkg::SPE_W) + 1;

    // per-sample decode
    logic [XW-1:0] spe_x, max_x, n_x, bwin_x, bw_x, sg_x, lg_x, long_x, i_x, d_x;
    logic          win_err, in_base, in_gate, short_hit, long_hit, last;

    // running accumulators
    logic [CNT_W-1:0] idx_reg, scnt_reg, lcnt_reg;
    logic [SUM_W-1:0] bsum_reg, ssum_reg, lsum_reg;
    logic [CNT_W-1:0] scnt_upd, lcnt_upd;
    logic [SUM_W-1:0] bsum_upd, ssum_upd, lsum_upd;

    // end-of-event values
    logic [CNT_W-1:0]  scnt_f_reg, lcnt_f_reg, bw_f_reg;
    logic [SUM_W-1:0]  ssum_f_reg, lsum_f_reg;
    logic              err_f_reg;
    logic [DIVD_W-1:0] dvd_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W:0]    trial;
    logic              qbit;
    logic [DIVD_W-1:0] quo;
    logic [BASE_W-1:0] base;
    logic [CHARGE_W-1:0] prod_s_reg, prod_l_reg, prod_s_next, prod_l_next;
    logic [CHARGE_W-1:0] qs_next, ql_next;

    logic                m_tvalid_reg;
    logic [BASE_W-1:0]   base_out_reg;
    logic [CHARGE_W-1:0] qs_out_reg, ql_out_reg;
    logic                err_out_reg;

    always_comb begin
        spe_x   = XW'(cfg.samples_per_event);
        max_x   = XW'(MAX_SAMPLES);
        if (spe_x == '0) n_x = XW'(1);
        else if (spe_x > max_x) n_x = max_x;
        else n_x = spe_x;

        win_err = (cfg.pretrigger_len <= cfg.pregate_len);
        bwin_x  = win_err ? '0 : XW'(cfg.pretrigger_len - cfg.pregate_len);
        bw_x    = (bwin_x < n_x) ? bwin_x : n_x;
        sg_x    = XW'(cfg.short_gate_len);
        lg_x    = XW'(cfg.long_gate_len);
        long_x  = (lg_x > sg_x) ? lg_x : sg_x;

        i_x       = event_start ? '0 : XW'(idx_reg);
        d_x       = i_x - bwin_x;
        in_base   = (i_x < bw_x);
        in_gate   = (i_x >= bwin_x) && (i_x < n_x);
        short_hit = in_gate && (d_x < sg_x);
        long_hit  = in_gate && (d_x < long_x);
        last      = ((i_x + XW'(1)) >= n_x);

        bsum_upd = (event_start ? '0 : bsum_reg) + (in_base ? SUM_W'(sample) : '0);
        ssum_upd = (event_start ? '0 : ssum_reg) + (short_hit ? SUM_W'(sample) : '0);
        lsum_upd = (event_start ? '0 : lsum_reg) + (long_hit ? SUM_W'(sample) : '0);
        scnt_upd = (event_start ? '0 : scnt_reg) + CNT_W'(short_hit);
        lcnt_upd = (event_start ? '0 : lcnt_reg) + CNT_W'(long_hit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            bsum_reg <= '0;
            ssum_reg <= '0;
            lsum_reg <= '0;
            scnt_reg <= '0;
            lcnt_reg <= '0;
        end else if (cmd.accept) begin
            if (last) begin
                idx_reg  <= '0;
                bsum_reg <= '0;
                ssum_reg <= '0;
                lsum_reg <= '0;
                scnt_reg <= '0;
                lcnt_reg <= '0;
            end else begin
                idx_reg  <= i_x[CNT_W-1:0] + CNT_W'(1);
                bsum_reg <= bsum_upd;
                ssum_reg <= ssum_upd;
                lsum_reg <= lsum_upd;
                scnt_reg <= scnt_upd;
                lcnt_reg <= lcnt_upd;
            end
        end
    end

    // restoring divider, one quotient bit per step; quotient shifts into dvd_reg
    assign trial = {rem_reg, dvd_reg[DIVD_W-1]};
    assign qbit  = (trial >= {1'b0, bw_f_reg});

    always_ff @(posedge aclk) begin
        if (cmd.accept && last) begin
            dvd_reg    <= DIVD_W'(bsum_upd) << FRAC_BITS;
            rem_reg    <= '0;
            ssum_f_reg <= ssum_upd;
            lsum_f_reg <= lsum_upd;
            scnt_f_reg <= scnt_upd;
            lcnt_f_reg <= lcnt_upd;
            bw_f_reg   <= bw_x[CNT_W-1:0];
            err_f_reg  <= win_err;
        end else if (cmd.div_step) begin
            rem_reg <= qbit ? CNT_W'(trial - {1'b0, bw_f_reg}) : trial[CNT_W-1:0];
            dvd_reg <= {dvd_reg[DIVD_W-2:0], qbit};
        end
    end

    // empty window divides by zero; baseline forced to 0
    assign quo  = (bw_f_reg == '0) ? '0 : dvd_reg;
    assign base = quo[BASE_W-1:0];

    // a window shrunk mid event can push the quotient past BASE_W; the charges
    // use the whole quotient, only the baseline output is cut
    assign prod_s_next = CHARGE_W'(scnt_f_reg) * CHARGE_W'(quo);
    assign prod_l_next = CHARGE_W'(lcnt_f_reg) * CHARGE_W'(quo);

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_s_reg <= prod_s_next;
            prod_l_reg <= prod_l_next;
        end
    end

    assign qs_next = prod_s_reg - (CHARGE_W'(ssum_f_reg) << FRAC_BITS);
    assign ql_next = prod_l_reg - (CHARGE_W'(lsum_f_reg) << FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            base_out_reg <= base;
            qs_out_reg   <= qs_next;
            ql_out_reg   <= ql_next;
            err_out_reg  <= err_f_reg;
        end
    end

    assign sts.last     = last;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid     = m_tvalid_reg;
    assign baseline_avg = base_out_reg;
    assign charge_short = qs_out_reg;
    assign charge_long  = ql_out_reg;
    assign window_error = err_out_reg;

endmodule

FILE: design/psd_gated_charge_integrator.sv
// Accepts one sample per cycle while an event accumulates.
// After the last sample of an event the input stalls while a bit-serial divider
// forms the baseline, a multiply state forms the products and a load state waits
// for the output register to be free and loads it; m_axis_tvalid rises after that
// load. aresetn (synchronous) restores the default configuration, clears the
// running sums and drops m_axis_tvalid.
module psd_gated_charge_integrator #(
    parameter int MAX_SAMPLES = psd_gci_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = psd_gci_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = psd_gci_pkg::FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic                                 cfg_wr_en,
    input  logic [psd_gci_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [psd_gci_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // event_start
    input  logic                                 s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // baseline_avg, charge_short, charge_long
    output logic [((2*$clog2(MAX_SAMPLES+1)+3*(SAMPLE_BITS+FRAC_BITS)+7)/8)*8-1:0]
                                                 m_axis_tdata,
    // window_error
    output logic                                 m_axis_tuser
);

    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W    = SAMPLE_BITS + $clog2(MAX_SAMPLES);
    localparam int BASE_W   = SAMPLE_BITS + FRAC_BITS;
    localparam int CHARGE_W = CNT_W + BASE_W;
    localparam int OUT_W    = ((2 * CNT_W + 3 * BASE_W + 7) / 8) * 8;

    psd_gci_pkg::psd_gci_cfg_t cfg_reg;
    psd_gci_pkg::psd_gci_cmd_t cmd;
    psd_gci_pkg::psd_gci_sts_t sts;

    logic [BASE_W-1:0]   baseline_avg;
    logic [CHARGE_W-1:0] charge_short, charge_long;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pretrigger_len    <= psd_gci_pkg::PRETRIGGER_LEN_RST;
            cfg_reg.pregate_len       <= psd_gci_pkg::PREGATE_LEN_RST;
            cfg_reg.short_gate_len    <= psd_gci_pkg::SHORT_GATE_LEN_RST;
            cfg_reg.long_gate_len     <= psd_gci_pkg::LONG_GATE_LEN_RST;
            cfg_reg.samples_per_event <= psd_gci_pkg::SAMPLES_PER_EVENT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                psd_gci_pkg::CFG_PRETRIGGER_LEN:
                    cfg_reg.pretrigger_len <= cfg_wdata[psd_gci_pkg::LEN_W-1:0];
                psd_gci_pkg::CFG_PREGATE_LEN:
                    cfg_reg.pregate_len <= cfg_wdata[psd_gci_pkg::LEN_W-1:0];
                psd_gci_pkg::CFG_SHORT_GATE_LEN:
                    cfg_reg.short_gate_len <= cfg_wdata[psd_gci_pkg::LEN_W-1:0];
                psd_gci_pkg::CFG_LONG_GATE_LEN:
                    cfg_reg.long_gate_len <= cfg_wdata[psd_gci_pkg::LEN_W-1:0];
                psd_gci_pkg::CFG_SAMPLES_PER_EVENT:
                    cfg_reg.samples_per_event <= cfg_wdata[psd_gci_pkg::SPE_W-1:0];
                default: ;
            endcase
        end
    end

    psd_gci_ctrl #(
        .DIV_STEPS (SUM_W + FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    psd_gci_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .sample       (s_axis_tdata[SAMPLE_BITS-1:0]),
        .event_start  (s_axis_tuser),
        .cmd          (cmd),
        .sts          (sts),
        .m_tready     (m_axis_tready),
        .m_tvalid     (m_axis_tvalid),
        .baseline_avg (baseline_avg),
        .charge_short (charge_short),
        .charge_long  (charge_long),
        .window_error (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'({charge_long, charge_short, baseline_avg});

endmodule

FILE: design/psd_gci_checker.sv
`include "psd_gated_charge_integrator_defines.svh"

module psd_gci_checker #(
    parameter int MAX_SAMPLES = psd_gci_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = psd_gci_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = psd_gci_pkg::FRAC_BITS_DEF
) (
    input logic aclk,
    input logic aresetn,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((2*$clog2(MAX_SAMPLES+1)+3*(SAMPLE_BITS+FRAC_BITS)+7)/8)*8-1:0]
                m_axis_tdata,
    input logic m_axis_tuser
);

    localparam int BASE_W = SAMPLE_BITS + FRAC_BITS;

    // a pending result is never withdrawn
    `PSD_GCI_ASSERT_NEXT(a_m_valid_hold, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

    // a result is loaded only from the post-division states, where input is stalled
    `PSD_GCI_ASSERT_NOW(a_load_while_stalled, aclk, aresetn,
        m_axis_tvalid && !$past(m_axis_tvalid), !$past(s_axis_tready),
        "result appeared while input side was open")

    // input closes only after the transaction that ended an event
    `PSD_GCI_ASSERT_NOW(a_ready_falls_on_accept, aclk, aresetn,
        $fell(s_axis_tready), $past(s_axis_tvalid),
        "s_axis_tready fell without an accepted transaction")

    // empty baseline window forces a zero baseline
    `PSD_GCI_ASSERT_NOW(a_err_zero_base, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser, m_axis_tdata[BASE_W-1:0] == '0,
        "window error with nonzero baseline")

endmodule

bind psd_gated_charge_integrator psd_gci_checker #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
) u_psd_gci_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
